>>> hw/rtl/tsao_pkg.sv
// ----------------------------------------------------------------------------
// tsao_pkg
// Shared types, widths, format codes and format decode for the tensor
// surface address offset block.
// ----------------------------------------------------------------------------
package tsao_pkg;

    // offset arithmetic wraps at this width, the port shows the low 32 bits
    localparam int OFFSET_BITS = 32;
    localparam int OUT_W       = 32;

    localparam int COL_W      = 13;
    localparam int ROW_W      = 13;
    localparam int CHAN_W     = 12;
    localparam int DIM_W      = 14;
    localparam int CCNT_W     = 13;
    localparam int STRIDE_W   = 32;
    localparam int FMT_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // shift amounts for element size and channel group size
    localparam int BSH_W   = 2;
    localparam int GSH_W   = 3;
    // local term: (col << 5 | chan low bits) << 2 fits in 20 bits
    localparam int SMALL_W = COL_W + 5 + 2;
    localparam int PRE_W   = SMALL_W - 2;

    localparam logic [GSH_W-1:0] GRP32_SH = GSH_W'(5);
    localparam logic [GSH_W-1:0] GRP8_SH  = GSH_W'(3);
    localparam logic [GSH_W-1:0] GRP16_SH = GSH_W'(4);
    localparam int               PACK4_SH = 2;

    localparam logic [BSH_W-1:0] BPE1_SH = BSH_W'(0);
    localparam logic [BSH_W-1:0] BPE2_SH = BSH_W'(1);
    localparam logic [BSH_W-1:0] BPE4_SH = BSH_W'(2);

    typedef logic [OFFSET_BITS-1:0] off_t;

    // format codes
    localparam logic [FMT_W-1:0] FMT_SINGLE_8     = FMT_W'(0);
    localparam logic [FMT_W-1:0] FMT_SIZE_ONLY    = FMT_W'(1);
    localparam logic [FMT_W-1:0] FMT_PACK4_16     = FMT_W'(8);
    localparam logic [FMT_W-1:0] FMT_PACK4_8      = FMT_W'(13);
    localparam logic [FMT_W-1:0] FMT_SIZE_ONLY_LO = FMT_W'(14);
    localparam logic [FMT_W-1:0] FMT_SIZE_ONLY_HI = FMT_W'(20);
    localparam logic [FMT_W-1:0] FMT_CHW_8        = FMT_W'(37);
    localparam logic [FMT_W-1:0] FMT_CHW_16A      = FMT_W'(38);
    localparam logic [FMT_W-1:0] FMT_CHW_16B      = FMT_W'(39);
    localparam logic [FMT_W-1:0] FMT_GRP32_8      = FMT_W'(40);
    localparam logic [FMT_W-1:0] FMT_GRP8_8       = FMT_W'(41);
    localparam logic [FMT_W-1:0] FMT_GRP16_16A    = FMT_W'(42);
    localparam logic [FMT_W-1:0] FMT_GRP16_16B    = FMT_W'(43);
    localparam logic [FMT_W-1:0] FMT_CHW_32       = FMT_W'(44);
    localparam logic [FMT_W-1:0] FMT_GRP8_32      = FMT_W'(45);
    localparam logic [FMT_W-1:0] FMT_PACK3_A      = FMT_W'(46);
    localparam logic [FMT_W-1:0] FMT_PACK3_B      = FMT_W'(47);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORMAT      = 3'd0,
        REG_WIDTH       = 3'd1,
        REG_HEIGHT      = 3'd2,
        REG_CHAN_COUNT  = 3'd3,
        REG_LINE_STRIDE = 3'd4,
        REG_SURF_STRIDE = 3'd5
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_NO_SIZE = 3'd2,
        ST_CHAN    = 3'd3,
        ST_LAYOUT  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        LAY_NONE   = 3'd0,
        LAY_SINGLE = 3'd1,
        LAY_PACK3  = 3'd2,
        LAY_PACK4  = 3'd3,
        LAY_GROUP  = 3'd4,
        LAY_CHW    = 3'd5
    } layout_t;

    typedef struct packed {
        logic [FMT_W-1:0]    fmt;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [CCNT_W-1:0]   chan_cnt;
        logic [STRIDE_W-1:0] line_stride;
        logic [STRIDE_W-1:0] surf_stride;
    } cfg_t;

    typedef struct packed {
        logic             has_size;
        logic [BSH_W-1:0] bsh;
        logic [GSH_W-1:0] gsh;
        layout_t          layout;
    } fmt_info_t;

    function automatic fmt_info_t fmt_decode(input logic [FMT_W-1:0] fmt);
        fmt_info_t info;
        info.has_size = 1'b1;
        info.bsh      = BPE1_SH;
        info.gsh      = '0;
        info.layout   = LAY_NONE;
        case (fmt)
            FMT_SINGLE_8:  info.layout = LAY_SINGLE;
            FMT_PACK3_A,
            FMT_PACK3_B:   info.layout = LAY_PACK3;
            FMT_PACK4_8:   info.layout = LAY_PACK4;
            FMT_PACK4_16:
            begin
                info.layout = LAY_PACK4;
                info.bsh    = BPE2_SH;
            end
            FMT_GRP32_8:
            begin
                info.layout = LAY_GROUP;
                info.gsh    = GRP32_SH;
            end
            FMT_GRP8_8:
            begin
                info.layout = LAY_GROUP;
                info.gsh    = GRP8_SH;
            end
            FMT_GRP8_32:
            begin
                info.layout = LAY_GROUP;
                info.gsh    = GRP8_SH;
                info.bsh    = BPE4_SH;
            end
            FMT_GRP16_16A,
            FMT_GRP16_16B:
            begin
                info.layout = LAY_GROUP;
                info.gsh    = GRP16_SH;
                info.bsh    = BPE2_SH;
            end
            FMT_CHW_8:     info.layout = LAY_CHW;
            FMT_CHW_16A,
            FMT_CHW_16B:
            begin
                info.layout = LAY_CHW;
                info.bsh    = BPE2_SH;
            end
            FMT_CHW_32:
            begin
                info.layout = LAY_CHW;
                info.bsh    = BPE4_SH;
            end
            default:
            begin
                // element size known but no layout, or no element size at all
                info.has_size = (fmt == FMT_SIZE_ONLY) ||
                                ((fmt >= FMT_SIZE_ONLY_LO) && (fmt <= FMT_SIZE_ONLY_HI));
            end
        endcase
        return info;
    endfunction

endpackage

>>> hw/rtl/tensor_surface_address_offset_top.sv
// ----------------------------------------------------------------------------
// tensor_surface_address_offset_top
// Byte offset of one surface element from its column, row and channel.
// ----------------------------------------------------------------------------
// Three-stage pipeline: input register, product register, result register.
// One request is taken every cycle as long as out_ready is high, and each
// result passes the input, product and result registers in order. The row term
// (row * line_stride) and the plane term (channel or channel group times
// surface_stride, or column times channel_count for packed 3-channel) each
// use one 13x32 multiplier ahead of the product register; the final
// three-way add sits ahead of the result register. When the result is
// stalled the stages fill up and in_ready drops once all three hold a
// request. Configuration must only be written while the pipeline is empty.
module tensor_surface_address_offset_top (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_wen,
    input  logic [tsao_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsao_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tsao_pkg::COL_W-1:0]       col_index,
    input  logic [tsao_pkg::ROW_W-1:0]       row_index,
    input  logic [tsao_pkg::CHAN_W-1:0]      chan_index,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tsao_pkg::OUT_W-1:0]       byte_offset,
    output logic [tsao_pkg::STATUS_W-1:0]    status
);

    tsao_pkg::cfg_t      cfg;
    tsao_pkg::fmt_info_t info;

    // stage 1: input register
    logic                          s1_valid_reg;
    logic [tsao_pkg::COL_W-1:0]    s1_col_reg;
    logic [tsao_pkg::ROW_W-1:0]    s1_row_reg;
    logic [tsao_pkg::CHAN_W-1:0]   s1_chan_reg;

    // stage 2: product register
    logic                          s2_valid_reg;
    tsao_pkg::off_t                s2_row_term_reg;
    tsao_pkg::off_t                s2_plane_term_reg;
    tsao_pkg::off_t                s2_local_term_reg;
    tsao_pkg::status_t             s2_status_reg;

    // stage 3: result register
    logic                          s3_valid_reg;
    logic [tsao_pkg::OUT_W-1:0]    s3_offset_reg;
    tsao_pkg::status_t             s3_status_reg;

    logic adv2;
    logic adv3;

    tsao_pkg::status_t             status_next;
    logic [tsao_pkg::CHAN_W-1:0]   grp_idx;
    logic [tsao_pkg::CHAN_W-1:0]   grp_mask;
    logic [tsao_pkg::PRE_W-1:0]    local_pre;
    logic [tsao_pkg::SMALL_W-1:0]  local_term;
    logic [tsao_pkg::COL_W-1:0]    mul_x;
    logic [tsao_pkg::STRIDE_W-1:0] mul_y;
    tsao_pkg::off_t                row_term_next;
    tsao_pkg::off_t                plane_term_next;
    tsao_pkg::off_t                offset_sum;

    tsao_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign info = tsao_pkg::fmt_decode(cfg.fmt);

    // handshake: a stage moves when the next one is empty or moving
    assign adv3     = s2_valid_reg && (!s3_valid_reg || out_ready);
    assign adv2     = s1_valid_reg && (!s2_valid_reg || adv3);
    assign in_ready = !s1_valid_reg || adv2;

    // ---- stage 1 -> 2: checks and products ----
    always_comb
    begin
        if (({1'b0, s1_col_reg} >= cfg.width) || ({1'b0, s1_row_reg} >= cfg.height) ||
            ({1'b0, s1_chan_reg} >= cfg.chan_cnt))
            status_next = tsao_pkg::ST_RANGE;
        else if (!info.has_size)
            status_next = tsao_pkg::ST_NO_SIZE;
        else if ((info.layout == tsao_pkg::LAY_SINGLE) && (s1_chan_reg != '0))
            status_next = tsao_pkg::ST_CHAN;
        else if (info.layout == tsao_pkg::LAY_NONE)
            status_next = tsao_pkg::ST_LAYOUT;
        else
            status_next = tsao_pkg::ST_OK;
    end

    assign grp_idx  = s1_chan_reg >> info.gsh;
    assign grp_mask = (tsao_pkg::CHAN_W'(1) << info.gsh) - tsao_pkg::CHAN_W'(1);

    // term that needs no multiplier, already scaled by element size
    always_comb
    begin
        local_pre  = '0;
        local_term = '0;
        case (info.layout)
            tsao_pkg::LAY_SINGLE:
                local_term = tsao_pkg::SMALL_W'(s1_col_reg);
            tsao_pkg::LAY_PACK3:
                local_term = tsao_pkg::SMALL_W'(s1_chan_reg);
            tsao_pkg::LAY_PACK4:
            begin
                local_pre  = (tsao_pkg::PRE_W'(s1_col_reg) << tsao_pkg::PACK4_SH) +
                             tsao_pkg::PRE_W'(s1_chan_reg);
                local_term = tsao_pkg::SMALL_W'(local_pre) << info.bsh;
            end
            tsao_pkg::LAY_GROUP:
            begin
                local_pre  = (tsao_pkg::PRE_W'(s1_col_reg) << info.gsh) |
                             tsao_pkg::PRE_W'(s1_chan_reg & grp_mask);
                local_term = tsao_pkg::SMALL_W'(local_pre) << info.bsh;
            end
            tsao_pkg::LAY_CHW:
                local_term = tsao_pkg::SMALL_W'(s1_col_reg) << info.bsh;
            default:
                local_term = '0;
        endcase
    end

    // shared plane multiplier operands
    always_comb
    begin
        case (info.layout)
            tsao_pkg::LAY_PACK3:
            begin
                mul_x = s1_col_reg;
                mul_y = tsao_pkg::STRIDE_W'(cfg.chan_cnt);
            end
            tsao_pkg::LAY_GROUP:
            begin
                mul_x = tsao_pkg::COL_W'(grp_idx);
                mul_y = cfg.surf_stride;
            end
            tsao_pkg::LAY_CHW:
            begin
                mul_x = tsao_pkg::COL_W'(s1_chan_reg);
                mul_y = cfg.surf_stride;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign row_term_next   = tsao_pkg::OFFSET_BITS'(s1_row_reg) *
                             tsao_pkg::OFFSET_BITS'(cfg.line_stride);
    assign plane_term_next = tsao_pkg::OFFSET_BITS'(mul_x) *
                             tsao_pkg::OFFSET_BITS'(mul_y);

    // ---- stage 2 -> 3: sum ----
    assign offset_sum = s2_row_term_reg + s2_plane_term_reg + s2_local_term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (!s2_valid_reg || adv3)
                s2_valid_reg <= s1_valid_reg;
            if (!s3_valid_reg || out_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_col_reg  <= col_index;
            s1_row_reg  <= row_index;
            s1_chan_reg <= chan_index;
        end
        if (adv2)
        begin
            s2_row_term_reg   <= row_term_next;
            s2_plane_term_reg <= plane_term_next;
            s2_local_term_reg <= tsao_pkg::OFFSET_BITS'(local_term);
            s2_status_reg     <= status_next;
        end
        if (adv3)
        begin
            s3_offset_reg <= (s2_status_reg == tsao_pkg::ST_OK) ?
                             tsao_pkg::OUT_W'(offset_sum) : '0;
            s3_status_reg <= s2_status_reg;
        end
    end

    assign out_valid   = s3_valid_reg;
    assign byte_offset = s3_offset_reg;
    assign status      = s3_status_reg;

endmodule

>>> hw/rtl/tsao_cfg.sv
// ----------------------------------------------------------------------------
// tsao_cfg
// Configuration register file: write-only, indexed, unknown indexes ignored.
// ----------------------------------------------------------------------------
module tsao_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [tsao_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsao_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tsao_pkg::cfg_t                   cfg
);

    tsao_pkg::cfg_t cfg_reg;
    tsao_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                tsao_pkg::REG_FORMAT:
                    cfg_next.fmt = cfg_data[tsao_pkg::FMT_W-1:0];
                tsao_pkg::REG_WIDTH:
                    cfg_next.width = cfg_data[tsao_pkg::DIM_W-1:0];
                tsao_pkg::REG_HEIGHT:
                    cfg_next.height = cfg_data[tsao_pkg::DIM_W-1:0];
                tsao_pkg::REG_CHAN_COUNT:
                    cfg_next.chan_cnt = cfg_data[tsao_pkg::CCNT_W-1:0];
                tsao_pkg::REG_LINE_STRIDE:
                    cfg_next.line_stride = cfg_data[tsao_pkg::STRIDE_W-1:0];
                tsao_pkg::REG_SURF_STRIDE:
                    cfg_next.surf_stride = cfg_data[tsao_pkg::STRIDE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/tsao_checker.sv
// ----------------------------------------------------------------------------
// tsao_checker
// Port-level checks for the tensor surface address offset block.
// ----------------------------------------------------------------------------
module tsao_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [tsao_pkg::OUT_W-1:0]       byte_offset,
    input logic [tsao_pkg::STATUS_W-1:0]    status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_offset) && $stable(status))
        else $error("result changed while stalled");

    // errored requests carry a zero offset
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != tsao_pkg::ST_OK) |-> byte_offset == '0)
        else $error("nonzero offset with error status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= tsao_pkg::STATUS_W'(tsao_pkg::ST_LAYOUT))
        else $error("status code out of range");

    // input is only held off by a stalled output
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind tensor_surface_address_offset_top tsao_checker u_tsao_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_offset (byte_offset),
    .status      (status)
);
